>>> rtl/rhbs_pkg.sv
// Shared types and constants for the range header block splitter.
package rhbs_pkg;

    // Width of the block size as the divider sees it: twice a 32-bit register.
    localparam int SIZE_W = 33;
    // Width of the reported offsets and block index.
    localparam int OUT_OFS_W = 48;
    localparam int IDX_W = 6;

    // Register indexes on the write channel.
    localparam logic CFG_ENABLE    = 1'b0;
    localparam logic CFG_HALF_SIZE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SKIP  = 3'd1,
        ST_DECL  = 3'd2,
        ST_UNSAT = 3'd3,
        ST_MANY  = 3'd4
    } status_t;

    // Control from the sequencer to the byte parser.
    typedef struct packed {
        logic step;   // consume one header byte
        logic nul;    // apply the end-of-value step
        logic clr;    // return to the reset state
    } parse_ctl_t;

    // Status from the byte parser to the sequencer.
    typedef struct packed {
        logic    skip;
        status_t verdict;
    } parse_info_t;

endpackage

>>> rtl/range_header_block_split_top.sv
// Top level of the range header block splitter: sequencer, configuration and output register.
// Header bytes are taken while the sequencer is idle. After the last byte the block closes
// the parse (FIN, then EVAL); an error or skip status then goes to the output register.
// A satisfiable range runs two divisions on the shared divider, start then end offset,
// then emits one block per cycle while the receiver takes them. Reset clears the parser,
// the sequencer, the output register and the registers (enable off, half_block_size
// 1048576); no clearing pass is needed.
module range_header_block_split_top #(
    parameter int MAX_BLOCKS  = 64,
    parameter int OFFSET_BITS = 48
) (
    input  logic          clk,
    input  logic          rst_n,

    // Header byte stream.
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,    // [7:0] hdr_byte
    input  logic          s_tlast,    // last_byte

    // Result stream.
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [199:0]  m_tdata,    // [47:0] req_start, [95:48] req_end,
                                      // [143:96] block_start, [191:144] block_end,
                                      // [197:192] block_index, [199:198] zero
    output logic [2:0]    m_tuser,    // [2:0] status
    output logic          m_tlast,    // run_last

    // Register write channel.
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data
);

    localparam int OW = rhbs_pkg::OUT_OFS_W;
    localparam int IW = rhbs_pkg::IDX_W;
    localparam int SW = rhbs_pkg::SIZE_W;

    typedef enum logic [2:0] {
        S_IDLE, S_FIN, S_EVAL, S_DIV_S, S_DIV_E, S_CHECK, S_EMIT
    } state_t;

    // Configuration registers; the user must write them only while the block is idle (not enforced here).
    logic         enable_reg;
    logic [31:0]  half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            half_reg   <= 32'd1048576;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rhbs_pkg::CFG_ENABLE:    enable_reg <= cfg_data[0];
                rhbs_pkg::CFG_HALF_SIZE: half_reg   <= cfg_data;
                default:                 enable_reg <= enable_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // A zero half size counts as one; the block length is twice the half size.
    logic [31:0]  half_eff;
    logic [SW-1:0] size_blk;
    logic [OW-1:0] size_out;
    logic [OW-1:0] size_m1;

    assign half_eff = (half_reg == '0) ? 32'd1 : half_reg;
    assign size_blk = {half_eff, 1'b0};
    assign size_out = OW'(size_blk);
    assign size_m1  = size_out - OW'(1);

    // Byte parser.
    rhbs_pkg::parse_ctl_t    pctl;
    rhbs_pkg::parse_info_t   pinfo;
    logic [OFFSET_BITS-1:0]  start_acc;
    logic [OFFSET_BITS-1:0]  end_acc;

    rhbs_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (pctl),
        .hdr_byte  (s_tdata),
        .info      (pinfo),
        .start_acc (start_acc),
        .end_acc   (end_acc)
    );

    // Shared divider: first the start offset, then the end offset, by the block length.
    logic                    div_go;
    logic [OFFSET_BITS-1:0]  div_num;
    logic                    div_busy;
    logic                    div_done;
    logic [OFFSET_BITS-1:0]  div_quot;
    logic [SW-1:0]           div_rem;

    rhbs_div #(
        .NUM_W (OFFSET_BITS),
        .DEN_W (SW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go),
        .num   (div_num),
        .den   (size_blk),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    // Sequencer state and output register.
    state_t                  state_reg, state_next;
    logic [OFFSET_BITS-1:0]  i_reg, i_next;
    logic [OW-1:0]           bs_reg, bs_next;
    logic [IW-1:0]           k_reg, k_next;
    logic [IW-1:0]           last_idx_reg, last_idx_next;
    logic                    many_reg, many_next;

    logic                    m_valid_reg, m_valid_next;
    rhbs_pkg::status_t       st_reg, st_next;
    logic [OW-1:0]           rs_reg, rs_next;
    logic [OW-1:0]           re_reg, re_next;
    logic [OW-1:0]           obs_reg, obs_next;
    logic [OW-1:0]           obe_reg, obe_next;
    logic [IW-1:0]           idx_reg, idx_next;
    logic                    olast_reg, olast_next;

    logic                    out_free;
    rhbs_pkg::status_t       status_now;
    logic [OFFSET_BITS-1:0]  span;
    logic                    is_last_blk;

    always_comb
    begin
        out_free    = !m_valid_reg || m_tready;
        status_now  = (!enable_reg || pinfo.skip) ? rhbs_pkg::ST_SKIP : pinfo.verdict;
        span        = div_quot - i_reg;
        is_last_blk = (k_reg == last_idx_reg);

        state_next    = state_reg;
        i_next        = i_reg;
        bs_next       = bs_reg;
        k_next        = k_reg;
        last_idx_next = last_idx_reg;
        many_next     = many_reg;

        m_valid_next = m_valid_reg && !m_tready;
        st_next      = st_reg;
        rs_next      = rs_reg;
        re_next      = re_reg;
        obs_next     = obs_reg;
        obe_next     = obe_reg;
        idx_next     = idx_reg;
        olast_next   = olast_reg;

        pctl    = '0;
        div_go  = 1'b0;
        div_num = start_acc;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    pctl.step = 1'b1;
                    if (s_tlast)
                        state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // Close the value as if a NUL byte followed it.
                pctl.nul   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (status_now == rhbs_pkg::ST_OK)
                begin
                    div_go     = 1'b1;
                    div_num    = start_acc;
                    state_next = S_DIV_S;
                end
                else if (out_free)
                begin
                    m_valid_next = 1'b1;
                    st_next      = status_now;
                    rs_next      = '0;
                    re_next      = '0;
                    obs_next     = '0;
                    obe_next     = '0;
                    idx_next     = '0;
                    olast_next   = 1'b1;
                    pctl.clr     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DIV_S:
            begin
                if (div_done)
                begin
                    // The first block starts at the start offset less its remainder.
                    i_next     = div_quot;
                    bs_next    = OW'(start_acc) - OW'(div_rem);
                    div_go     = 1'b1;
                    div_num    = end_acc;
                    state_next = S_DIV_E;
                end
            end
            S_DIV_E:
            begin
                if (div_done)
                begin
                    many_next     = (span >= OFFSET_BITS'(MAX_BLOCKS));
                    last_idx_next = span[IW-1:0];
                    k_next        = '0;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!many_reg)
                    state_next = S_EMIT;
                else if (out_free)
                begin
                    m_valid_next = 1'b1;
                    st_next      = rhbs_pkg::ST_MANY;
                    rs_next      = OW'(start_acc);
                    re_next      = OW'(end_acc);
                    obs_next     = '0;
                    obe_next     = '0;
                    idx_next     = '0;
                    olast_next   = 1'b1;
                    pctl.clr     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    st_next      = rhbs_pkg::ST_OK;
                    rs_next      = OW'(start_acc);
                    re_next      = OW'(end_acc);
                    obs_next     = bs_reg;
                    obe_next     = bs_reg + size_m1;
                    idx_next     = k_reg;
                    olast_next   = is_last_blk;
                    bs_next      = bs_reg + size_out;
                    k_next       = k_reg + IW'(1);
                    if (is_last_blk)
                    begin
                        pctl.clr   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            i_reg        <= '0;
            bs_reg       <= '0;
            k_reg        <= '0;
            last_idx_reg <= '0;
            many_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            st_reg       <= rhbs_pkg::ST_OK;
            rs_reg       <= '0;
            re_reg       <= '0;
            obs_reg      <= '0;
            obe_reg      <= '0;
            idx_reg      <= '0;
            olast_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            bs_reg       <= bs_next;
            k_reg        <= k_next;
            last_idx_reg <= last_idx_next;
            many_reg     <= many_next;
            m_valid_reg  <= m_valid_next;
            st_reg       <= st_next;
            rs_reg       <= rs_next;
            re_reg       <= re_next;
            obs_reg      <= obs_next;
            obe_reg      <= obe_next;
            idx_reg      <= idx_next;
            olast_reg    <= olast_next;
        end
    end

    // Only the idle state takes bytes; the output register lets a new header start while
    // the final result of the previous one still waits.
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = st_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {2'b00, idx_reg, obe_reg, obs_reg, re_reg, rs_reg};

    // The divider never runs while header bytes are being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> !s_tready)
        else $error("divider busy while the byte port is ready");

    // A division finishes only in the states that wait for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_S || state_reg == S_DIV_E))
        else $error("division finished outside a division state");

    // Plain status results carry no offsets.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == 3'(rhbs_pkg::ST_SKIP) || m_tuser == 3'(rhbs_pkg::ST_DECL)
                     || m_tuser == 3'(rhbs_pkg::ST_UNSAT)) |-> (m_tdata == '0))
        else $error("status result carries nonzero payload");

    // Only a block of a longer run may leave without the last mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tuser == 3'(rhbs_pkg::ST_OK)))
        else $error("non-final result with a status other than ok");

endmodule

>>> rtl/rhbs_parser.sv
// Byte-at-a-time parser of the range header value with a decimal accumulator.
module rhbs_parser #(
    parameter int OFFSET_BITS = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rhbs_pkg::parse_ctl_t    ctl,
    input  logic [7:0]              hdr_byte,
    output rhbs_pkg::parse_info_t   info,
    output logic [OFFSET_BITS-1:0]  start_acc,
    output logic [OFFSET_BITS-1:0]  end_acc
);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5a;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [3:0] {
        PH_PREFIX, PH_LEAD, PH_START, PH_SP1, PH_LEAD2,
        PH_END, PH_SP2, PH_DONE, PH_SKIP
    } phase_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h62;  // b
            3'd1:    ch = 8'h79;  // y
            3'd2:    ch = 8'h74;  // t
            3'd3:    ch = 8'h65;  // e
            3'd4:    ch = 8'h73;  // s
            default: ch = 8'h3d;  // =
        endcase
        return ch;
    endfunction

    phase_t                    phase_reg, phase_next;
    logic [2:0]                pcount_reg, pcount_next;
    logic [OFFSET_BITS-1:0]    start_reg, start_next;
    logic [OFFSET_BITS-1:0]    end_reg, end_next;
    rhbs_pkg::status_t         verdict_reg, verdict_next;

    logic [7:0]                ch;
    logic [7:0]                lc;
    logic                      is_dig;
    logic [3:0]                digit;
    logic [OFFSET_BITS-1:0]    acc_src;
    logic [OFFSET_BITS+3:0]    prod;
    logic                      acc_ovf;
    logic [OFFSET_BITS-1:0]    acc_val;
    rhbs_pkg::status_t         verdict_acc;
    rhbs_pkg::status_t         verdict_fin;

    always_comb
    begin
        ch     = ctl.nul ? CH_NUL : hdr_byte;
        lc     = (ch >= CH_UPA && ch <= CH_UPZ) ? ch + CASE_OFS : ch;
        is_dig = (ch >= CH_ZERO && ch <= CH_NINE);
        digit  = 4'(ch - CH_ZERO);

        // Multiply by ten as two shifted adds; any carry above the offset width overflows.
        acc_src = (phase_reg == PH_END)   ? end_reg :
                  (phase_reg == PH_START) ? start_reg : '0;
        prod    = ({4'b0, acc_src} << 3) + ({4'b0, acc_src} << 1)
                  + (OFFSET_BITS+4)'(digit);
        acc_ovf = |prod[OFFSET_BITS+3:OFFSET_BITS];
        acc_val = acc_ovf ? '1 : prod[OFFSET_BITS-1:0];
        verdict_acc = acc_ovf ? rhbs_pkg::ST_UNSAT : verdict_reg;
        verdict_fin = (verdict_reg != rhbs_pkg::ST_OK || start_reg > end_reg)
                      ? rhbs_pkg::ST_UNSAT : rhbs_pkg::ST_OK;

        phase_next   = phase_reg;
        pcount_next  = pcount_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        verdict_next = verdict_reg;

        if (ctl.clr)
        begin
            phase_next   = PH_PREFIX;
            pcount_next  = '0;
            start_next   = '0;
            end_next     = '0;
            verdict_next = rhbs_pkg::ST_OK;
        end
        else if (ctl.step && phase_reg == PH_PREFIX)
        begin
            if (pcount_reg < 3'd6 && lc != prefix_char(pcount_reg))
            begin
                phase_next = PH_SKIP;
            end
            pcount_next = pcount_reg + 3'd1;
            if (phase_next == PH_PREFIX && pcount_next >= 3'd6)
            begin
                phase_next = PH_LEAD;
            end
        end
        else if (ctl.step || ctl.nul)
        begin
            if (ctl.step && pcount_reg < 3'd7)
            begin
                pcount_next = pcount_reg + 3'd1;
            end
            case (phase_reg)
                PH_LEAD:
                begin
                    if (ch == CH_SPACE)
                    begin
                    end
                    else if (ch == CH_DASH)
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = rhbs_pkg::ST_DECL;
                    end
                    else if (is_dig)
                    begin
                        start_next   = acc_val;
                        verdict_next = verdict_acc;
                        phase_next   = PH_START;
                    end
                    else
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = rhbs_pkg::ST_UNSAT;
                    end
                end
                PH_START:
                begin
                    if (is_dig)
                    begin
                        start_next   = acc_val;
                        verdict_next = verdict_acc;
                    end
                    else if (ch == CH_SPACE)
                        phase_next = PH_SP1;
                    else if (ch == CH_DASH)
                        phase_next = PH_LEAD2;
                    else
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = rhbs_pkg::ST_UNSAT;
                    end
                end
                PH_SP1:
                begin
                    if (ch == CH_SPACE)
                    begin
                    end
                    else if (ch == CH_DASH)
                        phase_next = PH_LEAD2;
                    else
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = rhbs_pkg::ST_UNSAT;
                    end
                end
                PH_LEAD2:
                begin
                    if (ch == CH_SPACE)
                    begin
                    end
                    else if (ch == CH_COMMA || ch == CH_NUL)
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = rhbs_pkg::ST_DECL;
                    end
                    else if (is_dig)
                    begin
                        end_next     = acc_val;
                        verdict_next = verdict_acc;
                        phase_next   = PH_END;
                    end
                    else
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = rhbs_pkg::ST_UNSAT;
                    end
                end
                PH_END:
                begin
                    if (is_dig)
                    begin
                        end_next     = acc_val;
                        verdict_next = verdict_acc;
                    end
                    else if (ch == CH_SPACE)
                        phase_next = PH_SP2;
                    else if (ch == CH_NUL || ch == CH_CR)
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = verdict_fin;
                    end
                    else
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = rhbs_pkg::ST_UNSAT;
                    end
                end
                PH_SP2:
                begin
                    if (ch == CH_SPACE)
                    begin
                    end
                    else if (ch == CH_NUL || ch == CH_CR)
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = verdict_fin;
                    end
                    else
                    begin
                        phase_next   = PH_DONE;
                        verdict_next = rhbs_pkg::ST_UNSAT;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_PREFIX;
            pcount_reg  <= '0;
            start_reg   <= '0;
            end_reg     <= '0;
            verdict_reg <= rhbs_pkg::ST_OK;
        end
        else
        begin
            phase_reg   <= phase_next;
            pcount_reg  <= pcount_next;
            start_reg   <= start_next;
            end_reg     <= end_next;
            verdict_reg <= verdict_next;
        end
    end

    assign info.skip    = (phase_reg == PH_SKIP) || (phase_reg == PH_PREFIX)
                          || (pcount_reg < 3'd7);
    assign info.verdict = verdict_reg;
    assign start_acc    = start_reg;
    assign end_acc      = end_reg;

endmodule

>>> rtl/rhbs_div.sv
// Shared restoring divider, one quotient bit per cycle.
module rhbs_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 33
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              busy,
    output logic              done,
    output logic [NUM_W-1:0]  quot,
    output logic [DEN_W-1:0]  rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        diff  = trial - {1'b0, den};
        ge    = (trial >= {1'b0, den});

        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            num_next  = num;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The dividend shifts out at the top while quotient bits enter at the bottom.
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_next = {num_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = num_reg;
    assign rem  = rem_reg;

endmodule

>>> bench/tb_range_header_block_split_top.sv
// Self-checking testbench for range_header_block_split_top, with a built-in predictor.
module tb_range_header_block_split_top;

    localparam int MAX_BLOCKS   = 64;
    localparam int OFFSET_BITS  = 48;
    // Quiet cycles allowed before the run is declared hung. The slowest legitimate gap is
    // the long receiver hold-off below plus one full division pass.
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 50;
    localparam int RANDOM_BYTES = 60;

    localparam bit [63:0] MASK48      = 64'hFFFF_FFFF_FFFF;
    localparam bit [47:0] PREFIX_TEXT = "bytes=";
    localparam bit [7:0]  CH_NUL      = 8'h00;
    localparam bit [7:0]  CH_CR       = 8'h0D;
    localparam bit [7:0]  CH_SPACE    = 8'h20;
    localparam bit [7:0]  CH_COMMA    = 8'h2C;
    localparam bit [7:0]  CH_DASH     = 8'h2D;
    localparam bit [7:0]  CH_ZERO     = 8'h30;
    localparam bit [7:0]  CH_NINE     = 8'h39;
    localparam bit [7:0]  CH_UPPER_A  = 8'h41;
    localparam bit [7:0]  CH_UPPER_Z  = 8'h5A;
    localparam bit [7:0]  CASE_GAP    = 8'd32;

    // Phases of the header parser as the predictor tracks them.
    typedef enum int {
        PH_PREFIX, PH_LEAD, PH_START, PH_SP1, PH_LEAD2, PH_END, PH_SP2, PH_DONE, PH_SKIP
    } parse_phase_t;

    // One predicted result transfer.
    typedef struct {
        rhbs_pkg::status_t status;
        bit [47:0]         req_start;
        bit [47:0]         req_end;
        bit [47:0]         blk_start;
        bit [47:0]         blk_end;
        bit [5:0]          blk_index;
        bit                run_last;
    } block_rec_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = 8'h00;
    logic         s_tlast   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [199:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_index = 1'b0;
    logic [31:0]  cfg_data  = 32'h0;

    // Predictor copy of the registers and the parser state.
    bit                mdl_enable;
    bit [31:0]         mdl_half;
    parse_phase_t      mdl_phase;
    int unsigned       mdl_count;
    bit [63:0]         mdl_first;
    bit [63:0]         mdl_final;
    rhbs_pkg::status_t mdl_verdict;

    block_rec_t   block_q[$];
    bit [7:0]     hdr_bytes[$];
    int unsigned  results_due;
    int unsigned  bytes_sent;
    int unsigned  rx_count;
    int unsigned  err_count;
    int unsigned  sink_hold_req;
    bit           src_idle  = 1'b1;
    bit           sink_idle = 1'b1;

    range_header_block_split_top #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_parser();
        mdl_phase   = PH_PREFIX;
        mdl_count   = 0;
        mdl_first   = 64'd0;
        mdl_final   = 64'd0;
        mdl_verdict = rhbs_pkg::ST_OK;
    endfunction

    // Append one decimal digit; an offset past the 48-bit range saturates and
    // marks the header as not satisfiable.
    function automatic bit [63:0] add_digit(bit [63:0] acc, bit [3:0] d);
        bit [63:0] lim;
        lim = (64'd1 << OFFSET_BITS) - 64'd1;
        if (acc > (lim - 64'(d)) / 64'd10) begin
            mdl_verdict = rhbs_pkg::ST_UNSAT;
            return lim;
        end
        return acc * 64'd10 + 64'(d);
    endfunction

    function automatic void conclude(rhbs_pkg::status_t v);
        mdl_verdict = v;
        mdl_phase   = PH_DONE;
    endfunction

    function automatic void close_range();
        if (mdl_verdict != rhbs_pkg::ST_OK || mdl_first > mdl_final)
            conclude(rhbs_pkg::ST_UNSAT);
        else
            conclude(rhbs_pkg::ST_OK);
    endfunction

    // One byte after the prefix. A NUL stands for the end of the value.
    function automatic void step_parser(bit [7:0] c);
        bit       dig;
        bit [3:0] d;
        dig = (c >= CH_ZERO && c <= CH_NINE);
        d   = 4'(c - CH_ZERO);
        case (mdl_phase)
            PH_LEAD: begin
                if (c == CH_DASH)
                    conclude(rhbs_pkg::ST_DECL);
                else if (dig) begin
                    mdl_first = add_digit(64'd0, d);
                    mdl_phase = PH_START;
                end
                else if (c != CH_SPACE)
                    conclude(rhbs_pkg::ST_UNSAT);
            end
            PH_START: begin
                if (dig)
                    mdl_first = add_digit(mdl_first, d);
                else if (c == CH_SPACE)
                    mdl_phase = PH_SP1;
                else if (c == CH_DASH)
                    mdl_phase = PH_LEAD2;
                else
                    conclude(rhbs_pkg::ST_UNSAT);
            end
            PH_SP1: begin
                if (c == CH_DASH)
                    mdl_phase = PH_LEAD2;
                else if (c != CH_SPACE)
                    conclude(rhbs_pkg::ST_UNSAT);
            end
            PH_LEAD2: begin
                if (c == CH_COMMA || c == CH_NUL)
                    conclude(rhbs_pkg::ST_DECL);
                else if (dig) begin
                    mdl_final = add_digit(64'd0, d);
                    mdl_phase = PH_END;
                end
                else if (c != CH_SPACE)
                    conclude(rhbs_pkg::ST_UNSAT);
            end
            PH_END: begin
                if (dig)
                    mdl_final = add_digit(mdl_final, d);
                else if (c == CH_SPACE)
                    mdl_phase = PH_SP2;
                else if (c == CH_NUL || c == CH_CR)
                    close_range();
                else
                    conclude(rhbs_pkg::ST_UNSAT);
            end
            PH_SP2: begin
                if (c == CH_NUL || c == CH_CR)
                    close_range();
                else if (c != CH_SPACE)
                    conclude(rhbs_pkg::ST_UNSAT);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void push_block(rhbs_pkg::status_t st, bit [63:0] rs, bit [63:0] re,
                                       bit [63:0] bs, bit [63:0] be, bit [5:0] idx,
                                       bit lst);
        block_rec_t r;
        r.status    = st;
        r.req_start = rs[47:0];
        r.req_end   = re[47:0];
        r.blk_start = bs[47:0];
        r.blk_end   = be[47:0];
        r.blk_index = idx;
        r.run_last  = lst;
        block_q.push_back(r);
        results_due++;
    endfunction

    // Advance the predictor by one accepted header byte and queue what it causes.
    function automatic void split_range_byte(bit [7:0] c, bit last);
        bit [7:0]          lc;
        rhbs_pkg::status_t st;
        bit [63:0]         size;
        bit [63:0]         bi;
        bit [63:0]         bj;
        bit [63:0]         cnt;
        bit [63:0]         bs;
        bit [63:0]         k;
        if (mdl_phase == PH_PREFIX) begin
            lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_GAP : c;
            if (mdl_count < 6 && lc != PREFIX_TEXT[8 * (5 - mdl_count) +: 8])
                mdl_phase = PH_SKIP;
            mdl_count++;
            if (mdl_phase == PH_PREFIX && mdl_count >= 6)
                mdl_phase = PH_LEAD;
        end
        else begin
            if (mdl_count < 7)
                mdl_count++;
            step_parser(c);
        end
        if (!last)
            return;

        if (!mdl_enable || mdl_phase == PH_SKIP || mdl_phase == PH_PREFIX || mdl_count < 7)
            st = rhbs_pkg::ST_SKIP;
        else begin
            if (mdl_phase != PH_DONE)
                step_parser(CH_NUL);
            st = mdl_verdict;
        end

        if (st == rhbs_pkg::ST_OK) begin
            // A half size register of zero behaves as one.
            size = 64'd2 * ((mdl_half == 32'd0) ? 64'd1 : 64'(mdl_half));
            bi   = mdl_first / size;
            bj   = mdl_final / size;
            cnt  = bj - bi + 64'd1;
            if (cnt > MAX_BLOCKS)
                push_block(rhbs_pkg::ST_MANY, mdl_first, mdl_final, 64'd0, 64'd0, 6'd0,
                           1'b1);
            else begin
                for (k = 0; k < cnt; k++) begin
                    bs = (bi + k) * size;
                    push_block(rhbs_pkg::ST_OK, mdl_first, mdl_final, bs,
                               bs + size - 64'd1, 6'(k), k + 64'd1 == cnt);
                end
            end
        end
        else
            push_block(st, 64'd0, 64'd0, 64'd0, 64'd0, 6'd0, 1'b1);

        clear_parser();
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("ERROR result %0d: %s", rx_count, msg);
    endtask

    task automatic check_block();
        block_rec_t want;
        if (block_q.size() == 0) begin
            report($sformatf("unexpected result, status %0d", m_tuser));
            return;
        end
        want = block_q.pop_front();
        if (m_tuser !== want.status)
            report($sformatf("status got %0d want %0d", m_tuser, want.status));
        if (m_tdata[47:0] !== want.req_start)
            report($sformatf("req_start got %0h want %0h", m_tdata[47:0], want.req_start));
        if (m_tdata[95:48] !== want.req_end)
            report($sformatf("req_end got %0h want %0h", m_tdata[95:48], want.req_end));
        if (m_tdata[143:96] !== want.blk_start)
            report($sformatf("block_start got %0h want %0h", m_tdata[143:96],
                             want.blk_start));
        if (m_tdata[191:144] !== want.blk_end)
            report($sformatf("block_end got %0h want %0h", m_tdata[191:144], want.blk_end));
        if (m_tdata[197:192] !== want.blk_index)
            report($sformatf("block_index got %0d want %0d", m_tdata[197:192],
                             want.blk_index));
        if (m_tlast !== want.run_last)
            report($sformatf("run_last got %0b want %0b", m_tlast, want.run_last));
    endtask

    // Result receiver: every transfer is checked against the oldest prediction, then a
    // fresh stall is drawn. A hold-off request from the test replaces the stall.
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                check_block();
                rx_count++;
                stall_left = sink_idle ? $urandom_range(0, 7) : 0;
            end
            if (sink_hold_req != 0) begin
                stall_left    = sink_hold_req;
                sink_hold_req = 0;
            end
            if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: counts cycles without a transfer on any channel.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         quiet, block_q.size());
                $display("tb_range_header_block_split_top: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one header byte, after a random gap when src_idle is set, and hold it until the transfer.
    task automatic send_byte(bit [7:0] b, bit last);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        split_range_byte(b, last);
    endtask

    task automatic send_header();
        int unsigned n;
        n = hdr_bytes.size();
        for (int unsigned k = 0; k < n; k++)
            send_byte(hdr_bytes[k], k == n - 1);
        bytes_sent += n;
        hdr_bytes.delete();
    endtask

    function automatic void push_text(string s);
        for (int k = 0; k < s.len(); k++)
            hdr_bytes.push_back(s[k]);
    endfunction

    function automatic void push_number(bit [63:0] v);
        bit [7:0] digits[$];
        do begin
            digits.push_front(CH_ZERO + 8'(v % 64'd10));
            v = v / 64'd10;
        end while (v != 0);
        foreach (digits[k])
            hdr_bytes.push_back(digits[k]);
    endfunction

    function automatic void push_spaces(int unsigned n);
        repeat (n) hdr_bytes.push_back(CH_SPACE);
    endfunction

    task automatic run_header(string s);
        push_text(s);
        send_header();
    endtask

    // Let every predicted result leave, then give the block time to finish any work that
    // has no visible result yet, so that the registers are only written while it is idle.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (block_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(bit idx, bit [31:0] val);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == rhbs_pkg::CFG_ENABLE)
            mdl_enable = val[0];
        else
            mdl_half = val;
        cfg_valid <= 1'b0;
    endtask

    function automatic bit [63:0] block_len();
        return 64'd2 * ((mdl_half == 32'd0) ? 64'd1 : 64'(mdl_half));
    endfunction

    // A syntactically valid header with random case, spacing, offsets and terminator.
    function automatic void build_good_header();
        bit [63:0] size;
        bit [63:0] first;
        bit [63:0] fin;
        size = block_len();
        for (int k = 0; k < 6; k++) begin
            if (k < 5 && $urandom_range(0, 1) != 0)
                hdr_bytes.push_back(PREFIX_TEXT[8 * (5 - k) +: 8] - CASE_GAP);
            else
                hdr_bytes.push_back(PREFIX_TEXT[8 * (5 - k) +: 8]);
        end
        push_spaces($urandom_range(0, 2));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: first = 64'($urandom_range(0, 999));
            4, 5, 6:    first = {$urandom, $urandom} % (size * 64'd100);
            7, 8:       first = {$urandom, $urandom} & MASK48;
            default:    first = MASK48 - 64'($urandom_range(0, 3));
        endcase
        case ($urandom_range(0, 9))
            0:       fin = (first != 0) ? first - 64'd1 : 64'd0;
            7, 8:    fin = first + size * 64'($urandom_range(9, 70));
            9:       fin = first + ({$urandom, $urandom} & MASK48);
            default: fin = first + size * 64'($urandom_range(0, 8))
                           + {$urandom, $urandom} % size;
        endcase
        // Mostly keep the end in range; the rest exercises the offset overflow.
        if (fin > MASK48 && $urandom_range(0, 4) != 0)
            fin = MASK48;
        push_number(first);
        push_spaces($urandom_range(0, 1));
        hdr_bytes.push_back(CH_DASH);
        push_spaces($urandom_range(0, 1));
        push_number(fin);
        case ($urandom_range(0, 5))
            0: push_spaces($urandom_range(1, 2));
            1: begin
                hdr_bytes.push_back(CH_CR);
                repeat ($urandom_range(0, 3)) hdr_bytes.push_back(8'($urandom));
            end
            2: begin
                hdr_bytes.push_back(CH_NUL);
                repeat ($urandom_range(0, 3)) hdr_bytes.push_back(8'($urandom));
            end
            default: begin
            end
        endcase
    endfunction

    function automatic bit [31:0] pick_half();
        case ($urandom_range(0, 5))
            0:       return 32'd1;
            1:       return 32'($urandom_range(2, 64));
            2:       return 32'd1048576;
            3:       return $urandom;
            4:       return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(100, 5000));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Headers that are skipped: block disabled, wrong prefix, value too short; an upper-case prefix is accepted.
    task automatic test_skip_and_prefix();
        run_header("bytes=0-9");
        write_reg(rhbs_pkg::CFG_ENABLE, 32'd1);
        run_header("bytez=1-2");
        run_header("bytes=");
        run_header("b");
        run_header("BYTES=0-1");
    endtask

    // Headers that are declined: suffix ranges, missing end, a list after the dash.
    task automatic test_declined();
        run_header("bytes=-500");
        run_header("bytes=5-");
        run_header("bytes=5-,7-9");
        run_header("bytes= 5 - ");
        // Overflowed start, then declined by the missing end.
        run_header("bytes=999999999999999999-");
    endtask

    task automatic test_unsatisfiable();
        run_header("bytes=a-1");
        run_header("bytes=5x-6");
        run_header("bytes=5 6");
        run_header("bytes=1-2x");
        run_header("bytes=1-2 3");
        run_header("bytes=9-3");
        run_header("bytes=0-281474976710656");
        push_text("bytes=5");
        hdr_bytes.push_back(CH_NUL);
        push_text("-6");
        send_header();
    endtask

    // Carriage return and NUL end the value; spacing and the largest offset.
    task automatic test_terminators();
        push_text("bytes=0-99");
        hdr_bytes.push_back(CH_CR);
        hdr_bytes.push_back(8'hFF);
        push_text("x-");
        send_header();
        push_text("bytes=1-2");
        hdr_bytes.push_back(CH_NUL);
        push_text("zz");
        send_header();
        run_header("bytes=  1  -  2  ");
        run_header("bytes=281474976710655-281474976710655");
    endtask

    task automatic test_block_sizes();
        write_reg(rhbs_pkg::CFG_HALF_SIZE, 32'd1);
        run_header("bytes=0-127");
        run_header("bytes=1-128");
        write_reg(rhbs_pkg::CFG_HALF_SIZE, 32'd0);
        run_header("bytes=3-8");
        write_reg(rhbs_pkg::CFG_HALF_SIZE, 32'hFFFF_FFFF);
        run_header("bytes=0-0");
        run_header("bytes=281474976710655-281474976710655");
        write_reg(rhbs_pkg::CFG_HALF_SIZE, 32'd1048576);
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering headers, so
    // that the output side backs up into the input.
    task automatic test_backpressure();
        src_idle      = 1'b0;
        sink_hold_req = HOLD_CYCLES;
        repeat (4) begin
            push_text("bytes=0-");
            push_number(block_len() * 64'd3 - 64'd1);
            send_header();
        end
        run_header("junk");
        src_idle = 1'b1;
    endtask

    task automatic test_random_headers();
        int unsigned first_byte;
        int unsigned pos;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < RANDOM_BYTES)
        begin
            // Occasional register changes, each in a quiet gap between headers.
            if ($urandom_range(0, 11) == 0) begin
                if (!mdl_enable)
                    write_reg(rhbs_pkg::CFG_ENABLE, 32'd1);
                else if ($urandom_range(0, 3) == 0)
                    write_reg(rhbs_pkg::CFG_ENABLE, 32'd0);
                else
                    write_reg(rhbs_pkg::CFG_HALF_SIZE, pick_half());
            end
            if ($urandom_range(0, 7) == 0) begin
                src_idle  = $urandom_range(0, 2) != 0;
                sink_idle = $urandom_range(0, 2) != 0;
            end
            case ($urandom_range(0, 19))
                // Broken: one byte replaced anywhere, or the tail cut off.
                14, 15, 16: begin
                    build_good_header();
                    pos = $urandom_range(0, hdr_bytes.size() - 1);
                    if ($urandom_range(0, 1) != 0)
                        hdr_bytes[pos] = 8'($urandom);
                    else
                        while (hdr_bytes.size() > pos + 1)
                            void'(hdr_bytes.pop_back());
                end
                17, 18, 19: begin
                    repeat ($urandom_range(1, 12)) hdr_bytes.push_back(8'($urandom));
                end
                default: build_good_header();
            endcase
            send_header();
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        mdl_enable = 1'b0;
        mdl_half   = 32'd1048576;
        clear_parser();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_skip_and_prefix();
        test_declined();
        test_unsatisfiable();
        test_terminators();
        test_block_sizes();
        test_backpressure();
        test_random_headers();

        settle_block();
        if (err_count == 0)
            $display("tb_range_header_block_split_top: done, clean");
        else
            $display("tb_range_header_block_split_top: done, errors");
        $finish;
    end

endmodule
